@@ src/assert_macros.svh @@
// Assertion macros used by the port-level checker of the escape sequence decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ted assertion failed");

// Next-cycle implication, disabled while reset is held.
`define TED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ted assertion failed");

// Condition that must hold on the cycle after a reset edge.
`define TED_ASSERT_RST(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("ted reset assertion failed");

`endif

@@ src/ted_pkg.sv @@
// Types, command codes and sizes shared by the escape sequence decoder files.
`default_nettype none

package ted_pkg;

  // Sizes
  localparam int MAX_PARAMS = 16;
  localparam int IDX_W      = $clog2(MAX_PARAMS);
  localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
  localparam int VAL_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int ROWS_W     = 8;
  localparam int CMD_W      = 5;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 8'd24;

  // Result command codes
  localparam logic [CMD_W-1:0] CMD_UP         = 5'd0;
  localparam logic [CMD_W-1:0] CMD_DOWN       = 5'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT      = 5'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT       = 5'd3;
  localparam logic [CMD_W-1:0] CMD_COL        = 5'd4;
  localparam logic [CMD_W-1:0] CMD_ROW        = 5'd5;
  localparam logic [CMD_W-1:0] CMD_GOTO       = 5'd6;
  localparam logic [CMD_W-1:0] CMD_ERASE_DISP = 5'd7;
  localparam logic [CMD_W-1:0] CMD_ERASE_LINE = 5'd8;
  localparam logic [CMD_W-1:0] CMD_CLEAR_CHR  = 5'd9;
  localparam logic [CMD_W-1:0] CMD_FG         = 5'd10;
  localparam logic [CMD_W-1:0] CMD_BG         = 5'd11;
  localparam logic [CMD_W-1:0] CMD_REPORT     = 5'd12;
  localparam logic [CMD_W-1:0] CMD_SCROLL     = 5'd13;
  localparam logic [CMD_W-1:0] CMD_SAVE       = 5'd14;
  localparam logic [CMD_W-1:0] CMD_RESTORE    = 5'd15;
  localparam logic [CMD_W-1:0] CMD_KEYPAD     = 5'd16;
  localparam logic [CMD_W-1:0] CMD_REV_LF     = 5'd17;
  localparam logic [CMD_W-1:0] CMD_TITLE_BYTE = 5'd18;
  localparam logic [CMD_W-1:0] CMD_TITLE_END  = 5'd19;
  localparam logic [CMD_W-1:0] CMD_PLAIN      = 5'd20;

  // Default colours for a bare or reset SGR
  localparam logic [VAL_W-1:0] FG_DEFAULT = 16'd7;
  localparam logic [VAL_W-1:0] BG_DEFAULT = 16'd0;

  // Parser phase
  typedef enum logic [2:0] {
    PH_GROUND,
    PH_ESC,
    PH_CSI,
    PH_SKIP,
    PH_OSCNUM,
    PH_OSCTEXT
  } phase_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROC,
    S_BG,
    S_WRD,
    S_WCHK,
    S_WEND
  } ctl_state_t;

  // Source of the next beat loaded into the output register
  typedef enum logic [2:0] {
    EM_NONE,
    EM_MAIN,
    EM_SGR_FG,
    EM_SGR_BG,
    EM_PEND,
    EM_PEND_LAST
  } emit_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] arg_first;
    logic [VAL_W-1:0] arg_second;
    logic             flag;
    logic             last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic  load_byte;
    logic  commit;
    logic  walk_init;
    logic  capture;
    logic  idx_inc;
    emit_t emit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_res;
    logic is_sgr;
    logic cnt_zero;
    logic hit;
    logic pend_vld;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ src/ted_if.sv @@
// Valid/ready channel interfaces for the input bytes and the decoded results.
`default_nettype none

interface ted_byte_if import ted_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface ted_cmd_if import ted_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [VAL_W-1:0] arg_first;
  logic [VAL_W-1:0] arg_second;
  logic             flag;
  logic             last;

  modport source (output valid, output command, output arg_first, output arg_second,
                  output flag, output last, input ready);
  modport sink   (input valid, input command, input arg_first, input arg_second,
                  input flag, input last, output ready);
endinterface

`default_nettype wire

@@ src/ted_ctrl.sv @@
// Controller state machine: byte intake, result emission and the SGR parameter walk.
`default_nettype none

module ted_ctrl import ted_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  // The walk stalls when a hit needs the pending beat pushed out but the output is full
  logic walk_stall;
  assign walk_stall = stat.hit && stat.pend_vld && !stat.out_free;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PROC;
      end
      S_PROC: begin
        if (stat.is_sgr) begin
          if (!stat.cnt_zero) state_nxt = S_WRD;
          else if (stat.out_free) state_nxt = S_BG;
        end else if (!stat.has_res || stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_BG: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_WRD: begin
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        if (!walk_stall) state_nxt = stat.walk_last ? S_WEND : S_WRD;
      end
      S_WEND: begin
        if (!stat.pend_vld || stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.load_byte = 1'b0;
    cmd.commit    = 1'b0;
    cmd.walk_init = 1'b0;
    cmd.capture   = 1'b0;
    cmd.idx_inc   = 1'b0;
    cmd.emit      = EM_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_byte = in_valid;
      end
      S_PROC: begin
        if (stat.is_sgr) begin
          if (!stat.cnt_zero) begin
            cmd.commit    = 1'b1;
            cmd.walk_init = 1'b1;
          end else if (stat.out_free) begin
            cmd.commit = 1'b1;
            cmd.emit   = EM_SGR_FG;
          end
        end else if (!stat.has_res) begin
          cmd.commit = 1'b1;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          cmd.emit   = EM_MAIN;
        end
      end
      S_BG: begin
        if (stat.out_free) cmd.emit = EM_SGR_BG;
      end
      S_WRD: begin
        // read address is presented from the index register
      end
      S_WCHK: begin
        if (!walk_stall) begin
          cmd.capture = 1'b1;
          cmd.idx_inc = !stat.walk_last;
          if (stat.hit && stat.pend_vld) cmd.emit = EM_PEND;
        end
      end
      S_WEND: begin
        if (stat.pend_vld && stat.out_free) cmd.emit = EM_PEND_LAST;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/ted_dp.sv @@
// Datapath: parse state, parameter store, byte decode, SGR classifier and output register.
`default_nettype none

module ted_dp import ted_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              out_ready,
  input  logic              cfg_we,
  input  logic [ROWS_W-1:0] cfg_wdata,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  output result_t           out_res
);

  // Characters the parser looks at
  localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_BEL    = 8'h07;
  localparam logic [BYTE_W-1:0] CH_LBRACK = "[";
  localparam logic [BYTE_W-1:0] CH_RBRACK = "]";
  localparam logic [BYTE_W-1:0] CH_SEMI   = ";";
  localparam logic [BYTE_W-1:0] CH_QMARK  = "?";
  localparam logic [BYTE_W-1:0] CH_0      = "0";
  localparam logic [BYTE_W-1:0] CH_9      = "9";
  localparam logic [BYTE_W-1:0] CH_7      = "7";
  localparam logic [BYTE_W-1:0] CH_8      = "8";
  localparam logic [BYTE_W-1:0] CH_EQ     = "=";
  localparam logic [BYTE_W-1:0] CH_GT     = ">";
  localparam logic [BYTE_W-1:0] CH_UM     = "M";
  localparam logic [BYTE_W-1:0] CH_UA     = "A";
  localparam logic [BYTE_W-1:0] CH_UB     = "B";
  localparam logic [BYTE_W-1:0] CH_UC     = "C";
  localparam logic [BYTE_W-1:0] CH_UD     = "D";
  localparam logic [BYTE_W-1:0] CH_UG     = "G";
  localparam logic [BYTE_W-1:0] CH_LD     = "d";
  localparam logic [BYTE_W-1:0] CH_UH     = "H";
  localparam logic [BYTE_W-1:0] CH_UJ     = "J";
  localparam logic [BYTE_W-1:0] CH_UK     = "K";
  localparam logic [BYTE_W-1:0] CH_UP     = "P";
  localparam logic [BYTE_W-1:0] CH_LM     = "m";
  localparam logic [BYTE_W-1:0] CH_LN     = "n";
  localparam logic [BYTE_W-1:0] CH_LR     = "r";

  // SGR and status values
  localparam logic [VAL_W-1:0] SGR_RESET  = 16'd0;
  localparam logic [VAL_W-1:0] SGR_FG_LO  = 16'd30;
  localparam logic [VAL_W-1:0] SGR_FG_HI  = 16'd37;
  localparam logic [VAL_W-1:0] SGR_FG_DEF = 16'd39;
  localparam logic [VAL_W-1:0] SGR_BG_LO  = 16'd40;
  localparam logic [VAL_W-1:0] SGR_BG_HI  = 16'd47;
  localparam logic [VAL_W-1:0] SGR_BG_DEF = 16'd49;
  localparam logic [VAL_W-1:0] DSR_CURSOR = 16'd6;
  localparam logic [VAL_W-1:0] ERASE_MAX  = 16'd2;
  localparam logic [VAL_W-1:0] TITLE_MAX  = 16'd2;
  localparam logic [VAL_W-1:0] ONE        = 16'd1;

  // Decimal accumulate, saturating at the top of the 16-bit range
  function automatic logic [VAL_W-1:0] add_digit(input logic [VAL_W-1:0] v,
                                                 input logic [3:0] d);
    logic [VAL_W+3:0] t;
    t = ({4'b0000, v} << 3) + ({4'b0000, v} << 1) + (VAL_W + 4)'(d);
    if (|t[VAL_W+3:VAL_W]) return {VAL_W{1'b1}};
    return t[VAL_W-1:0];
  endfunction

  // Parse state
  logic [BYTE_W-1:0] byte_r;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic              in_dig_r, in_dig_nxt;
  logic [VAL_W-1:0]  title_r, title_nxt;
  logic [VAL_W-1:0]  p0_r, p1_r;
  logic [ROWS_W-1:0] rows_r;

  // Parameter store and walk
  logic [VAL_W-1:0]  mem [MAX_PARAMS];
  logic [VAL_W-1:0]  rdata_r;
  logic [IDX_W-1:0]  idx_r;
  result_t           pend_r;
  logic              pend_vld_r;

  // Output register
  logic              out_vld_r;
  result_t           out_r;

  // Decode results
  result_t           res_c;
  logic              has_res_c;
  logic              is_sgr_c;
  logic              clr_c;
  logic              wr_c;
  logic [IDX_W-1:0]  wr_addr_c;
  logic [VAL_W-1:0]  wr_data_c;
  logic              is_dig;
  logic [3:0]        dig_val;
  logic [CNT_W-1:0]  cnt_m1;
  logic [VAL_W-1:0]  mv_arg;
  logic [VAL_W-1:0]  top_c;
  logic [VAL_W-1:0]  bot_c;
  logic [VAL_W-1:0]  rows_ext;
  logic              title_ok;
  result_t           sgr_res_c;
  logic              hit_c;
  logic              out_free;

  assign is_dig   = (byte_r >= CH_0) && (byte_r <= CH_9);
  assign dig_val  = byte_r[3:0];
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign rows_ext = VAL_W'(rows_r);
  assign mv_arg   = (cnt_r != '0) ? p0_r : ONE;
  assign top_c    = (p0_r != '0) ? p0_r : ONE;
  assign bot_c    = (p1_r != '0) ? p1_r : rows_ext;
  assign title_ok = title_r <= TITLE_MAX;
  assign out_free = !out_vld_r || out_ready;

  // Byte decode and next parse state
  always_comb begin
    res_c       = '0;
    has_res_c   = 1'b0;
    is_sgr_c    = 1'b0;
    clr_c       = 1'b0;
    wr_c        = 1'b0;
    wr_addr_c   = cnt_m1[IDX_W-1:0];
    wr_data_c   = '0;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    in_dig_nxt  = in_dig_r;
    title_nxt   = title_r;
    case (phase_r)
      PH_GROUND: begin
        if (byte_r == CH_ESC) begin
          phase_nxt = PH_ESC;
        end else begin
          has_res_c       = 1'b1;
          res_c.command   = CMD_PLAIN;
          res_c.arg_first = VAL_W'(byte_r);
        end
      end
      PH_ESC: begin
        phase_nxt = PH_GROUND;
        case (byte_r)
          CH_LBRACK: begin
            clr_c     = 1'b1;
            phase_nxt = PH_CSI;
          end
          CH_RBRACK: begin
            clr_c     = 1'b1;
            title_nxt = '0;
            phase_nxt = PH_OSCNUM;
          end
          CH_7: begin
            has_res_c     = 1'b1;
            res_c.command = CMD_SAVE;
          end
          CH_8: begin
            has_res_c     = 1'b1;
            res_c.command = CMD_RESTORE;
          end
          CH_EQ: begin
            has_res_c     = 1'b1;
            res_c.command = CMD_KEYPAD;
            res_c.flag    = 1'b1;
          end
          CH_GT: begin
            has_res_c     = 1'b1;
            res_c.command = CMD_KEYPAD;
          end
          CH_UM: begin
            has_res_c     = 1'b1;
            res_c.command = CMD_REV_LF;
          end
          default: begin
            has_res_c = 1'b0;
          end
        endcase
      end
      PH_CSI: begin
        if (is_dig || byte_r == CH_SEMI) begin
          // a digit or ';' outside a digit run opens a new parameter slot
          if (!in_dig_r) begin
            wr_c = 1'b1;
            if (cnt_r < CNT_W'(MAX_PARAMS)) begin
              wr_addr_c = cnt_r[IDX_W-1:0];
              cnt_nxt   = cnt_r + CNT_W'(1);
            end else begin
              wr_addr_c = IDX_W'(MAX_PARAMS - 1);
            end
          end
          if (is_dig) begin
            wr_c       = 1'b1;
            wr_data_c  = add_digit(in_dig_r ? acc_r : '0, dig_val);
            acc_nxt    = wr_data_c;
            in_dig_nxt = 1'b1;
          end else begin
            acc_nxt    = '0;
            in_dig_nxt = 1'b0;
          end
        end else if (byte_r == CH_QMARK) begin
          // private marker: no effect on any result
          in_dig_nxt = in_dig_r;
        end else begin
          // final byte
          phase_nxt  = (byte_r == CH_LBRACK) ? PH_SKIP : PH_GROUND;
          in_dig_nxt = 1'b0;
          case (byte_r)
            CH_UA: begin
              has_res_c = 1'b1; res_c.command = CMD_UP; res_c.arg_first = mv_arg;
            end
            CH_UB: begin
              has_res_c = 1'b1; res_c.command = CMD_DOWN; res_c.arg_first = mv_arg;
            end
            CH_UC: begin
              has_res_c = 1'b1; res_c.command = CMD_RIGHT; res_c.arg_first = mv_arg;
            end
            CH_UD: begin
              has_res_c = 1'b1; res_c.command = CMD_LEFT; res_c.arg_first = mv_arg;
            end
            CH_UG: begin
              has_res_c = 1'b1; res_c.command = CMD_COL; res_c.arg_first = mv_arg;
            end
            CH_LD: begin
              has_res_c = 1'b1; res_c.command = CMD_ROW; res_c.arg_first = mv_arg;
            end
            CH_UH: begin
              has_res_c        = 1'b1;
              res_c.command    = CMD_GOTO;
              res_c.arg_first  = top_c;
              res_c.arg_second = (p1_r != '0) ? p1_r : ONE;
            end
            CH_UJ: begin
              has_res_c       = p0_r <= ERASE_MAX;
              res_c.command   = CMD_ERASE_DISP;
              res_c.arg_first = p0_r;
            end
            CH_UK: begin
              has_res_c       = p0_r <= ERASE_MAX;
              res_c.command   = CMD_ERASE_LINE;
              res_c.arg_first = p0_r;
            end
            CH_UP: begin
              has_res_c = 1'b1; res_c.command = CMD_CLEAR_CHR; res_c.arg_first = p0_r;
            end
            CH_LM: begin
              is_sgr_c = 1'b1;
            end
            CH_LN: begin
              has_res_c     = p0_r == DSR_CURSOR;
              res_c.command = CMD_REPORT;
            end
            CH_LR: begin
              has_res_c        = 1'b1;
              res_c.command    = CMD_SCROLL;
              res_c.arg_first  = top_c;
              res_c.arg_second = bot_c;
              res_c.flag       = (cnt_r != '0) && !((top_c == ONE) && (bot_c == rows_ext));
            end
            default: begin
              has_res_c = 1'b0;
            end
          endcase
        end
      end
      PH_SKIP: begin
        phase_nxt = PH_GROUND;
      end
      PH_OSCNUM: begin
        if (is_dig) begin
          title_nxt  = add_digit(title_r, dig_val);
          in_dig_nxt = 1'b1;
        end else begin
          phase_nxt  = (byte_r == CH_SEMI && in_dig_r) ? PH_OSCTEXT : PH_GROUND;
          in_dig_nxt = 1'b0;
        end
      end
      PH_OSCTEXT: begin
        if (byte_r == CH_BEL) begin
          phase_nxt     = PH_GROUND;
          has_res_c     = title_ok;
          res_c.command = CMD_TITLE_END;
        end else begin
          has_res_c       = title_ok;
          res_c.command   = CMD_TITLE_BYTE;
          res_c.arg_first = VAL_W'(byte_r);
        end
      end
      default: begin
        phase_nxt = PH_GROUND;
      end
    endcase
    if (clr_c) begin
      cnt_nxt    = '0;
      acc_nxt    = '0;
      in_dig_nxt = 1'b0;
    end
  end

  // SGR classifier on the parameter just read from the store
  always_comb begin
    sgr_res_c = '0;
    hit_c     = 1'b1;
    if (rdata_r == SGR_RESET || rdata_r == SGR_FG_DEF) begin
      sgr_res_c.command   = CMD_FG;
      sgr_res_c.arg_first = FG_DEFAULT;
    end else if (rdata_r >= SGR_FG_LO && rdata_r <= SGR_FG_HI) begin
      sgr_res_c.command   = CMD_FG;
      sgr_res_c.arg_first = rdata_r - SGR_FG_LO;
    end else if (rdata_r >= SGR_BG_LO && rdata_r <= SGR_BG_HI) begin
      sgr_res_c.command   = CMD_BG;
      sgr_res_c.arg_first = rdata_r - SGR_BG_LO;
    end else if (rdata_r == SGR_BG_DEF) begin
      sgr_res_c.command   = CMD_BG;
      sgr_res_c.arg_first = BG_DEFAULT;
    end else begin
      hit_c = 1'b0;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_GROUND;
      cnt_r    <= '0;
      acc_r    <= '0;
      in_dig_r <= 1'b0;
      title_r  <= '0;
      p0_r     <= '0;
      p1_r     <= '0;
      rows_r   <= ROWS_RESET;
    end else begin
      if (cfg_we) rows_r <= cfg_wdata;
      if (cmd.commit) begin
        phase_r  <= phase_nxt;
        cnt_r    <= cnt_nxt;
        acc_r    <= acc_nxt;
        in_dig_r <= in_dig_nxt;
        title_r  <= title_nxt;
        if (clr_c) begin
          p0_r <= '0;
          p1_r <= '0;
        end else if (wr_c) begin
          // first two slots are shadowed for the cursor, goto, erase, delete, report and region finals
          if (wr_addr_c == IDX_W'(0)) p0_r <= wr_data_c;
          if (wr_addr_c == IDX_W'(1)) p1_r <= wr_data_c;
        end
      end
    end
  end

  // Byte holding register
  always_ff @(posedge clk) begin
    if (cmd.load_byte) byte_r <= in_byte;
  end

  // Parameter store: one write port, one registered read port at the walk index
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_c) mem[wr_addr_c] <= wr_data_c;
    rdata_r <= mem[idx_r];
  end

  // Walk index and pending SGR beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      if (cmd.walk_init) begin
        idx_r      <= '0;
        pend_vld_r <= 1'b0;
      end else begin
        if (cmd.idx_inc) idx_r <= idx_r + IDX_W'(1);
        if (cmd.capture && hit_c) pend_vld_r <= 1'b1;
        else if (cmd.emit == EM_PEND_LAST) pend_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && hit_c) pend_r <= sgr_res_c;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EM_MAIN: begin
        out_r      <= res_c;
        out_r.last <= 1'b1;
      end
      EM_SGR_FG: begin
        out_r            <= '0;
        out_r.command    <= CMD_FG;
        out_r.arg_first  <= FG_DEFAULT;
      end
      EM_SGR_BG: begin
        out_r            <= '0;
        out_r.command    <= CMD_BG;
        out_r.arg_first  <= BG_DEFAULT;
        out_r.last       <= 1'b1;
      end
      EM_PEND: begin
        out_r      <= pend_r;
        out_r.last <= 1'b0;
      end
      EM_PEND_LAST: begin
        out_r      <= pend_r;
        out_r.last <= 1'b1;
      end
      default: begin
        out_r <= out_r;
      end
    endcase
  end

  // Status to the controller
  assign stat.has_res   = has_res_c;
  assign stat.is_sgr    = is_sgr_c;
  assign stat.cnt_zero  = cnt_r == '0;
  assign stat.hit       = hit_c;
  assign stat.pend_vld  = pend_vld_r;
  assign stat.walk_last = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
  assign stat.out_free  = out_free;

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

@@ src/terminal_escape_sequence_decoder_top.sv @@
// Top level of the terminal escape sequence decoder: controller, datapath and channels.
//
// Usage
//   in_ch  : one terminal output byte per beat (valid/ready).
//   out_ch : decoded commands (valid/ready); last marks the final beat caused by a byte.
//   cfg_we/cfg_wdata : writes screen_rows, the default bottom of the scroll region;
//   write only while the decoder is idle.
// Operation
//   A byte is taken while the decoder is idle and decoded in the next cycle; a beat
//   it yields is loaded into the output register once that register is free. A bare
//   SGR yields a default foreground beat and then a default background beat; an SGR
//   with parameters walks the one-read-port parameter store, reading each parameter
//   and then classifying it.
// Reset
//   rst_n is synchronous, active low; it returns the parser to the ground state,
//   clears the parameter count and title number, and sets screen_rows to 24.
// Backpressure
//   A finished beat waits in the output register while the next byte is taken;
//   the decoder only holds off when a new beat is due and the register is still full.
`default_nettype none

module terminal_escape_sequence_decoder_top import ted_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ted_byte_if.sink          in_ch,
  ted_cmd_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [ROWS_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;
  result_t  out_res;

  // Sequencing
  ted_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Parse state and result generation
  ted_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_ch.in_byte),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Channel hookup
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.command    = out_res.command;
  assign out_ch.arg_first  = out_res.arg_first;
  assign out_ch.arg_second = out_res.arg_second;
  assign out_ch.flag       = out_res.flag;
  assign out_ch.last       = out_res.last;

endmodule

`default_nettype wire

@@ src/ted_chk.sv @@
// Port-level checker for the escape sequence decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ted_chk import ted_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CMD_W-1:0] out_command,
  input logic [VAL_W-1:0] out_arg_first
);

  // A stalled beat stays up and unchanged
  `TED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `TED_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_command) && $stable(out_arg_first))

  // Only defined command codes leave the block
  `TED_ASSERT_IMPL(a_cmd_range, clk, rst_n, out_valid, out_command <= CMD_PLAIN)

  // One byte at a time: intake closes for the decode cycle
  `TED_ASSERT_NEXT(a_one_byte, clk, rst_n, in_valid && in_ready, !in_ready)

  // After reset the decoder is empty and ready
  `TED_ASSERT_RST(a_reset_idle, clk, rst_n, !out_valid && in_ready)

endmodule

bind terminal_escape_sequence_decoder_top ted_chk u_ted_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_command   (out_ch.command),
  .out_arg_first (out_ch.arg_first)
);

`default_nettype wire

@@ tb/sv/ted_command_check.sv @@
`timescale 1ns / 1ps
// Command stream checker for the escape sequence decoder: predicts and compares every beat.
module ted_command_check import ted_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ROWS_W-1:0] cfg_wdata,
  ted_byte_if               in_ch,
  ted_cmd_if                out_ch,
  output int                fail_count,
  output int                pending
);

  // Stream bytes with a meaning of their own
  localparam logic [BYTE_W-1:0] KEY_ESC     = 8'h1B;
  localparam logic [BYTE_W-1:0] KEY_BEL     = 8'h07;
  localparam logic [BYTE_W-1:0] CH_LBRACK   = "[";
  localparam logic [BYTE_W-1:0] CH_RBRACK   = "]";
  localparam logic [BYTE_W-1:0] CH_SEMI     = ";";
  localparam logic [BYTE_W-1:0] CH_QMARK    = "?";
  localparam logic [BYTE_W-1:0] CH_ZERO     = "0";
  localparam logic [BYTE_W-1:0] CH_NINE     = "9";
  localparam logic [BYTE_W-1:0] ESC_SAVE    = "7";
  localparam logic [BYTE_W-1:0] ESC_RESTORE = "8";
  localparam logic [BYTE_W-1:0] ESC_KP_APP  = "=";
  localparam logic [BYTE_W-1:0] ESC_KP_NUM  = ">";
  localparam logic [BYTE_W-1:0] ESC_REV_LF  = "M";
  // CSI final bytes
  localparam logic [BYTE_W-1:0] FIN_UP      = "A";
  localparam logic [BYTE_W-1:0] FIN_DOWN    = "B";
  localparam logic [BYTE_W-1:0] FIN_RIGHT   = "C";
  localparam logic [BYTE_W-1:0] FIN_LEFT    = "D";
  localparam logic [BYTE_W-1:0] FIN_COL     = "G";
  localparam logic [BYTE_W-1:0] FIN_ROW     = "d";
  localparam logic [BYTE_W-1:0] FIN_GOTO    = "H";
  localparam logic [BYTE_W-1:0] FIN_ED      = "J";
  localparam logic [BYTE_W-1:0] FIN_EL      = "K";
  localparam logic [BYTE_W-1:0] FIN_DCH     = "P";
  localparam logic [BYTE_W-1:0] FIN_SGR     = "m";
  localparam logic [BYTE_W-1:0] FIN_DSR     = "n";
  localparam logic [BYTE_W-1:0] FIN_STBM    = "r";
  // Parameter values
  localparam logic [VAL_W-1:0] VAL_SAT      = 16'hFFFF;
  localparam logic [VAL_W-1:0] SGR_FG_LO    = 16'd30;
  localparam logic [VAL_W-1:0] SGR_FG_HI    = 16'd37;
  localparam logic [VAL_W-1:0] SGR_FG_DEF   = 16'd39;
  localparam logic [VAL_W-1:0] SGR_BG_LO    = 16'd40;
  localparam logic [VAL_W-1:0] SGR_BG_HI    = 16'd47;
  localparam logic [VAL_W-1:0] SGR_BG_DEF   = 16'd49;
  localparam logic [VAL_W-1:0] DSR_CURSOR   = 16'd6;
  localparam logic [VAL_W-1:0] ERASE_MAX    = 16'd2;
  localparam logic [VAL_W-1:0] TITLE_OP_MAX = 16'd2;
  localparam logic [VAL_W-1:0] ONE          = 16'd1;
  localparam logic [VAL_W-1:0] NONE         = 16'd0;
  localparam int               CMDS_PER_BYTE = 16;
  localparam int               PRINT_LIMIT   = 40;

  // Predicted decoder state
  logic [ROWS_W-1:0] rows;
  phase_t            phase;
  logic [VAL_W-1:0]  params [MAX_PARAMS];
  logic [CNT_W-1:0]  param_cnt;
  logic              in_digit;
  logic              priv_mark;
  logic [VAL_W-1:0]  title_num;

  result_t expected_cmds [$];
  result_t staged [CMDS_PER_BYTE];
  int      n_staged;
  result_t want;
  int      beats_seen;

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_LIMIT) $display("[%0t] beat %0d: %s", $time, beats_seen, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] got,
                             input logic [VAL_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_val));
  endtask

  // Decimal accumulate, saturating at the top of the field
  function automatic logic [VAL_W-1:0] add_decimal(input logic [VAL_W-1:0] v,
                                                   input logic [BYTE_W-1:0] c);
    logic [31:0] t;
    t = 32'(v) * 32'd10 + 32'(c - CH_ZERO);
    return (t > 32'(VAL_SAT)) ? VAL_SAT : t[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] field_val(input int i);
    return (i < int'(param_cnt)) ? params[i] : NONE;
  endfunction

  // Commands caused by one byte collect here; extras past the cap are dropped
  task automatic stage(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] a,
                       input logic [VAL_W-1:0] b, input logic f);
    if (n_staged < CMDS_PER_BYTE) begin
      staged[n_staged].command    = cmd;
      staged[n_staged].arg_first  = a;
      staged[n_staged].arg_second = b;
      staged[n_staged].flag       = f;
      staged[n_staged].last       = 1'b0;
      n_staged++;
    end
  endtask

  task automatic clear_csi();
    for (int i = 0; i < MAX_PARAMS; i++) params[i] = NONE;
    param_cnt = '0;
    in_digit  = 1'b0;
    priv_mark = 1'b0;
  endtask

  // Past the last slot, a new field reuses it
  task automatic open_field();
    if (int'(param_cnt) < MAX_PARAMS) param_cnt++;
    else params[MAX_PARAMS-1] = NONE;
  endtask

  task automatic csi_final(input logic [BYTE_W-1:0] c);
    logic [VAL_W-1:0] p0, p1, v, top, bot;
    int               i;
    p0 = field_val(0);
    p1 = field_val(1);
    case (c)
      FIN_UP:    stage(CMD_UP,    (param_cnt != 0) ? p0 : ONE, NONE, 1'b0);
      FIN_DOWN:  stage(CMD_DOWN,  (param_cnt != 0) ? p0 : ONE, NONE, 1'b0);
      FIN_RIGHT: stage(CMD_RIGHT, (param_cnt != 0) ? p0 : ONE, NONE, 1'b0);
      FIN_LEFT:  stage(CMD_LEFT,  (param_cnt != 0) ? p0 : ONE, NONE, 1'b0);
      FIN_COL:   stage(CMD_COL,   (param_cnt != 0) ? p0 : ONE, NONE, 1'b0);
      FIN_ROW:   stage(CMD_ROW,   (param_cnt != 0) ? p0 : ONE, NONE, 1'b0);
      FIN_GOTO:  stage(CMD_GOTO, (p0 != 0) ? p0 : ONE, (p1 != 0) ? p1 : ONE, 1'b0);
      FIN_ED:    if (p0 <= ERASE_MAX) stage(CMD_ERASE_DISP, p0, NONE, 1'b0);
      FIN_EL:    if (p0 <= ERASE_MAX) stage(CMD_ERASE_LINE, p0, NONE, 1'b0);
      FIN_DCH:   stage(CMD_CLEAR_CHR, p0, NONE, 1'b0);
      FIN_SGR: begin
        // bare SGR resets both colours; else one command per known parameter
        if (param_cnt == 0) begin
          stage(CMD_FG, FG_DEFAULT, NONE, 1'b0);
          stage(CMD_BG, BG_DEFAULT, NONE, 1'b0);
        end
        for (i = 0; i < int'(param_cnt); i++) begin
          v = params[i];
          if (v == NONE || v == SGR_FG_DEF) stage(CMD_FG, FG_DEFAULT, NONE, 1'b0);
          else if (v >= SGR_FG_LO && v <= SGR_FG_HI) stage(CMD_FG, v - SGR_FG_LO, NONE, 1'b0);
          else if (v >= SGR_BG_LO && v <= SGR_BG_HI) stage(CMD_BG, v - SGR_BG_LO, NONE, 1'b0);
          else if (v == SGR_BG_DEF) stage(CMD_BG, BG_DEFAULT, NONE, 1'b0);
        end
      end
      FIN_DSR:   if (p0 == DSR_CURSOR) stage(CMD_REPORT, NONE, NONE, 1'b0);
      FIN_STBM: begin
        // zero edges take defaults; the full screen counts as no region
        top = (p0 != 0) ? p0 : ONE;
        bot = (p1 != 0) ? p1 : {8'h00, rows};
        stage(CMD_SCROLL, top, bot,
              (param_cnt != 0) && !(top == ONE && bot == {8'h00, rows}));
      end
      default: ;
    endcase
  endtask

  // Predict the commands caused by one accepted byte
  task automatic decode_byte(input logic [BYTE_W-1:0] c);
    logic    is_digit;
    result_t r;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    n_staged = 0;
    case (phase)
      PH_ESC: begin
        phase = PH_GROUND;
        if (c == CH_LBRACK) begin
          clear_csi();
          phase = PH_CSI;
        end else if (c == CH_RBRACK) begin
          clear_csi();
          title_num = NONE;
          phase     = PH_OSCNUM;
        end else if (c == ESC_SAVE)    stage(CMD_SAVE, NONE, NONE, 1'b0);
        else if (c == ESC_RESTORE)     stage(CMD_RESTORE, NONE, NONE, 1'b0);
        else if (c == ESC_KP_APP)      stage(CMD_KEYPAD, NONE, NONE, 1'b1);
        else if (c == ESC_KP_NUM)      stage(CMD_KEYPAD, NONE, NONE, 1'b0);
        else if (c == ESC_REV_LF)      stage(CMD_REV_LF, NONE, NONE, 1'b0);
      end
      PH_CSI: begin
        if (is_digit) begin
          if (!in_digit) begin
            open_field();
            in_digit = 1'b1;
          end
          params[param_cnt - 1'b1] = add_decimal(params[param_cnt - 1'b1], c);
        end else if (c == CH_SEMI) begin
          if (!in_digit) open_field();
          in_digit = 1'b0;
        end else if (c == CH_QMARK) begin
          priv_mark = 1'b1;
        end else begin
          csi_final(c);
          // a second '[' means an echoed key: skip the byte after it
          phase     = (c == CH_LBRACK) ? PH_SKIP : PH_GROUND;
          in_digit  = 1'b0;
          priv_mark = 1'b0;
        end
      end
      PH_SKIP: phase = PH_GROUND;
      PH_OSCNUM: begin
        if (is_digit) begin
          title_num = add_decimal(title_num, c);
          in_digit  = 1'b1;
        end else begin
          phase    = (c == CH_SEMI && in_digit) ? PH_OSCTEXT : PH_GROUND;
          in_digit = 1'b0;
        end
      end
      PH_OSCTEXT: begin
        if (c == KEY_BEL) begin
          if (title_num <= TITLE_OP_MAX) stage(CMD_TITLE_END, NONE, NONE, 1'b0);
          phase = PH_GROUND;
        end else if (title_num <= TITLE_OP_MAX) begin
          stage(CMD_TITLE_BYTE, {8'h00, c}, NONE, 1'b0);
        end
      end
      default: begin
        if (c == KEY_ESC) phase = PH_ESC;
        else stage(CMD_PLAIN, {8'h00, c}, NONE, 1'b0);
      end
    endcase
    for (int i = 0; i < n_staged; i++) begin
      r      = staged[i];
      r.last = (i == n_staged - 1);
      expected_cmds.push_back(r);
    end
  endtask

  task automatic reset_model();
    rows      = ROWS_RESET;
    phase     = PH_GROUND;
    title_num = NONE;
    clear_csi();
    expected_cmds.delete();
  endtask

  // Outputs are checked before the byte of the same edge is decoded
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) rows = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("command %0d arrived with none expected", out_ch.command));
        end else begin
          want = expected_cmds.pop_front();
          check_field("command", out_ch.command, want.command);
          check_field("arg_first", out_ch.arg_first, want.arg_first);
          check_field("arg_second", out_ch.arg_second, want.arg_second);
          check_field("flag", out_ch.flag, want.flag);
          check_field("last", out_ch.last, want.last);
        end
        beats_seen++;
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.in_byte);
    end
    pending = expected_cmds.size();
  end

endmodule

@@ tb/sv/terminal_escape_sequence_decoder_top_tb.sv @@
`timescale 1ns / 1ps
// Top of the escape sequence decoder testbench: clock, reset, byte stimulus and verdict.
module terminal_escape_sequence_decoder_top_tb;
  import ted_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int SETTLE_CYCLES = 48;
  localparam int DRAIN_LIMIT   = 20_000;
  localparam int BURST_BYTES   = 38;

  localparam logic [BYTE_W-1:0] KEY_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] KEY_BEL   = 8'h07;
  localparam logic [BYTE_W-1:0] KEY_CSI   = "[";
  localparam logic [BYTE_W-1:0] KEY_OSC   = "]";
  localparam logic [BYTE_W-1:0] KEY_SPACE = " ";
  localparam string CSI_FINALS = "ABCDGdHJKPmnrhlL[";
  localparam string ESC_FINALS = "78=>M";

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ROWS_W-1:0] cfg_wdata;
  int                fail_count;
  int                pending;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                bytes_fed;

  ted_byte_if in_ch ();
  ted_cmd_if  out_ch ();

  terminal_escape_sequence_decoder_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ted_command_check u_cmd_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One byte beat; valid stays high across back-to-back beats
  task automatic feed_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_fed++;
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
  endtask

  task automatic feed_esc(input logic [BYTE_W-1:0] b);
    feed_byte(KEY_ESC);
    feed_byte(b);
  endtask

  task automatic feed_csi(input string body, input logic [BYTE_W-1:0] fin);
    feed_byte(KEY_ESC);
    feed_byte(KEY_CSI);
    feed_text(body);
    feed_byte(fin);
  endtask

  task automatic feed_osc(input string body, input bit with_bel);
    feed_byte(KEY_ESC);
    feed_byte(KEY_OSC);
    feed_text(body);
    if (with_bel) feed_byte(KEY_BEL);
  endtask

  task automatic write_rows(input logic [ROWS_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait for every predicted command, then let the walk finish
  task automatic settle();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly small values and colour codes, some empty and some past saturation
  function automatic string random_field();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return "";
      1, 2:    return $sformatf("%0d", $urandom_range(9));
      3:       return $sformatf("%0d", $urandom_range(10, 29));
      9:       return $sformatf("%0d", $urandom_range(100, 99999));
      default: return $sformatf("%0d", $urandom_range(30, 49));
    endcase
  endfunction

  task automatic feed_random_csi();
    string            body;
    int               n_fields;
    int               pick;
    int               i;
    logic [BYTE_W-1:0] fin;
    body     = ($urandom_range(9) == 0) ? "?" : "";
    pick     = $urandom_range(9);
    n_fields = (pick < 2) ? 0 : (pick == 9) ? $urandom_range(14, 18) : $urandom_range(1, 4);
    for (i = 0; i < n_fields; i++) begin
      body = {body, random_field()};
      if (i < n_fields - 1 || $urandom_range(9) == 0) body = {body, ";"};
    end
    if ($urandom_range(9) == 0) fin = $urandom_range(255);
    else fin = CSI_FINALS[$urandom_range(CSI_FINALS.len() - 1)];
    feed_csi(body, fin);
    // echoed key: give it a byte to swallow
    if (fin == KEY_CSI) feed_byte($urandom_range(255));
  endtask

  task automatic feed_random_osc();
    int                pick;
    int                len;
    logic [BYTE_W-1:0] b;
    feed_byte(KEY_ESC);
    feed_byte(KEY_OSC);
    pick = $urandom_range(9);
    if (pick == 9) begin
      // broken number: bare ';' or digits ended by an arbitrary byte
      if ($urandom_range(1) == 0) begin
        feed_text(";");
      end else begin
        feed_text($sformatf("%0d", $urandom_range(9)));
        feed_byte($urandom_range(255));
      end
    end else begin
      if (pick < 7) feed_text($sformatf("%0d;", $urandom_range(2)));
      else if (pick == 7) feed_text($sformatf("%0d;", $urandom_range(3, 9)));
      else feed_text($sformatf("%0d;", $urandom_range(100, 99999)));
      len = $urandom_range(6);
      repeat (len) begin
        b = $urandom_range(255);
        if (b == KEY_BEL) b = KEY_SPACE;
        feed_byte(b);
      end
      feed_byte(KEY_BEL);
    end
  endtask

  task automatic feed_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      feed_byte($urandom_range(255));
    end else if (pick < 27) begin
      if ($urandom_range(3) == 0) feed_esc($urandom_range(255));
      else feed_esc(ESC_FINALS[$urandom_range(ESC_FINALS.len() - 1)]);
    end else if (pick < 77) begin
      feed_random_csi();
    end else if (pick < 92) begin
      feed_random_osc();
    end else begin
      repeat ($urandom_range(1, 4)) feed_byte($urandom_range(255));
    end
  endtask

  task automatic run_burst(input int n_bytes);
    int target;
    target = bytes_fed + n_bytes;
    while (bytes_fed < target) feed_random_item();
  endtask

  // Plain bytes, every escape, every CSI final and OSC case
  task automatic run_directed();
    feed_byte("A");
    feed_byte(8'h00);
    feed_byte(8'hFF);
    feed_esc("7");
    feed_esc("8");
    feed_esc("=");
    feed_esc(">");
    feed_esc("M");
    feed_esc("x");
    feed_esc(KEY_ESC);
    feed_byte("q");
    feed_csi("", "A");
    feed_csi("5", "B");
    feed_csi("0", "C");
    feed_csi("99999", "D");
    feed_csi("", "G");
    feed_csi("7", "d");
    feed_csi("", "H");
    feed_csi("0;0", "H");
    feed_csi("3;4", "H");
    feed_csi("", "J");
    feed_csi("1", "J");
    feed_csi("2", "K");
    feed_csi("3", "K");
    feed_csi("4", "P");
    feed_csi("", "P");
    feed_csi("", "m");
    feed_csi("0;31;39;42;49;55", "m");
    feed_csi(";", "m");
    // more fields than slots: the last slot keeps the newest value
    feed_csi("31;32;33;34;35;36;37;40;41;42;43;44;45;46;47;30;1;44", "m");
    feed_csi("6", "n");
    feed_csi("5", "n");
    feed_csi("", "r");
    feed_csi("2;10", "r");
    feed_csi("1;24", "r");
    feed_csi(";", "r");
    feed_csi("5;", "r");
    feed_csi("?25", "h");
    feed_csi("?", "l");
    feed_csi("3", "L");
    feed_csi("", "[");
    feed_byte(KEY_ESC);
    feed_byte("z");
    feed_osc("0;ab", 1'b1);
    feed_osc("2;", 1'b1);
    feed_osc("7;zz", 1'b1);
    feed_osc(";", 1'b0);
    feed_osc("1x", 1'b0);
    feed_osc("99999;q", 1'b1);
  endtask

  // Timeout guard
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_fed      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset row count, no idling
    run_directed();
    settle();

    // single-row screen, sender idling
    write_rows(8'd1);
    send_idle_pct = 60;
    run_burst(BURST_BYTES);
    settle();

    // tallest screen, receiver stalling
    write_rows(8'd255);
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    run_burst(BURST_BYTES);
    settle();

    // random height, light idling on both sides
    write_rows($urandom_range(2, 254));
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    run_burst(BURST_BYTES);
    settle();

    // back to the usual height at full rate
    write_rows(ROWS_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_burst(BURST_BYTES);
    settle();

    if (pending != 0) $display("%0d expected commands never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
